FILE: design/wtps_pkg.sv
// Shared types and constants of the weighted token profile scorer.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package wtps_pkg;

    // Fixed field widths of the item and result transfers.
    localparam int REQ_BITS       = 3;
    localparam int FSEL_BITS      = 3;
    localparam int SLOT_BITS      = 4;
    localparam int LEN_IN_BITS    = 5;
    localparam int WEIGHT_BITS    = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int SCORE_BITS     = 15;
    localparam int CODE_BITS      = 3;

    // Weight registers exist for the low fields only; higher fields weigh zero.
    localparam int WEIGHT_REGS  = 6;
    localparam int WREG_IDX_W   = 3;

    localparam int SCORE_MAX = 16383;
    localparam int SCORE_MIN = -16384;

    // Request codes.
    localparam logic [REQ_BITS-1:0] REQ_EXC_ENTRY = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_INC_ENTRY = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_INC_LEN   = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_EXC_LEN   = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_TOKEN     = 3'd4;
    localparam logic [REQ_BITS-1:0] REQ_END       = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_APPLY       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT0     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT_LAST = 3'd6;

    // List entry write strobes broadcast to every cell.
    typedef struct packed {
        logic inc;
        logic exc;
    } t_load;

    // Control part of a token probe moving down the chain.
    typedef struct packed {
        logic valid;
        logic ex_hit;
        logic inc_hit;
    } t_probe;

endpackage

`default_nettype wire

FILE: design/weighted_token_profile_scorer_core.sv
// Weighted token profile scorer. Load items fill per-field include and
// exclude token lists and set their lengths; token items are checked
// against the lists of their field, and an end item closes the candidate
// and produces one transfer with the weighted score, the reject flag and
// the code of the lowest rejecting field. A token item walks a chain of
// LIST_DEPTH cells, one list position per cell and one cell per cycle,
// and the result is folded into the per-field state on the edge after it
// leaves the last cell. For an end item a single multiply-accumulate unit
// visits one field per cycle, then the result moves into the output
// register once that register is free or emptying. The output register
// lets the next item enter while the result still waits to be taken.
// Configuration writes are always ready and must only be issued while
// the block is idle.
// Depends on wtps_pkg and wtps_cell.
`default_nettype none

module weighted_token_profile_scorer_core #(
    parameter int LIST_DEPTH  = 16,
    parameter int FIELD_COUNT = 6,
    parameter int TOKEN_BITS  = 12
) (
    input  wire                                         i_clk,
    input  wire                                         i_rst_n,
    // item channel
    input  wire                                         i_in_valid,
    output logic                                        o_in_stall,
    input  wire  [wtps_pkg::REQ_BITS-1:0]               i_req_type,
    input  wire  [wtps_pkg::FSEL_BITS-1:0]              i_field_sel,
    input  wire  [wtps_pkg::SLOT_BITS-1:0]              i_slot,
    input  wire  [TOKEN_BITS-1:0]                       i_token_id,
    input  wire  [wtps_pkg::LEN_IN_BITS-1:0]            i_list_length,
    // result channel
    output logic                                        o_out_valid,
    input  wire                                         i_out_stall,
    output logic signed [wtps_pkg::SCORE_BITS-1:0]      o_score,
    output logic                                        o_rejected,
    output logic [wtps_pkg::CODE_BITS-1:0]              o_reject_cause,
    // configuration write channel
    input  wire                                         i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire  [wtps_pkg::CFG_INDEX_BITS-1:0]         i_cfg_index,
    input  wire  [wtps_pkg::WEIGHT_BITS-1:0]            i_cfg_data
);

    localparam int FW     = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1;
    localparam int LW     = $clog2(LIST_DEPTH + 1);
    localparam int PROD_W = LW + 1 + wtps_pkg::WEIGHT_BITS;
    localparam int ACC_W  = (PROD_W + 3 > wtps_pkg::SCORE_BITS + 1)
                            ? PROD_W + 3 : wtps_pkg::SCORE_BITS + 1;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(wtps_pkg::SCORE_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(wtps_pkg::SCORE_MIN);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // configuration
    logic                                   r_apply;
    logic signed [wtps_pkg::WEIGHT_BITS-1:0] r_weight [wtps_pkg::WEIGHT_REGS];

    // per-field list lengths and candidate state
    logic [LW-1:0] r_inc_len [FIELD_COUNT];
    logic [LW-1:0] r_exc_len [FIELD_COUNT];
    logic [LW-1:0] r_best    [FIELD_COUNT];
    logic          r_seen    [FIELD_COUNT];

    // end-of-candidate accumulation
    logic [FW-1:0]                     r_fidx;
    logic signed [ACC_W-1:0]           r_acc;
    logic                              r_stop;
    logic [wtps_pkg::CODE_BITS-1:0]    r_code;

    // result register
    logic                                   r_out_valid;
    logic signed [wtps_pkg::SCORE_BITS-1:0] r_score;
    logic                                   r_rejected;
    logic [wtps_pkg::CODE_BITS-1:0]         r_reject_cause;

    // chain wiring, one slot per cell boundary
    wtps_pkg::t_probe      probe    [LIST_DEPTH + 1];
    logic [FW-1:0]         c_field  [LIST_DEPTH + 1];
    logic [TOKEN_BITS-1:0] c_token  [LIST_DEPTH + 1];
    logic [LW-1:0]         c_inc    [LIST_DEPTH + 1];
    logic [LW-1:0]         c_exc    [LIST_DEPTH + 1];
    logic [LW-1:0]         c_rank   [LIST_DEPTH + 1];

    logic           in_xfer;
    logic           field_ok;
    logic [FW-1:0]  fsel;
    logic [LW-1:0]  len_sat;
    wtps_pkg::t_load load;
    logic           launch;
    logic           start_sum;
    logic           scan_done;
    logic           emit_now;
    logic           sum_last;

    logic [FW-1:0]                           last_field;
    logic signed [wtps_pkg::WEIGHT_BITS-1:0] weight_sel;
    logic [LW-1:0]                           diff;
    logic signed [PROD_W-1:0]                diff_s;
    logic signed [PROD_W-1:0]                weight_s;
    logic signed [PROD_W-1:0]                prod;
    logic                                    take_term;
    logic signed [ACC_W-1:0]                 acc_sat;

    // ------------------------------------------------------------------
    // Item decode. Items are taken only in idle; one item is in flight.
    // ------------------------------------------------------------------
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && !o_in_stall;

    // Loads and tokens for a field without storage are dropped.
    assign field_ok = (32'(i_field_sel) < FIELD_COUNT);
    assign fsel     = FW'(i_field_sel);
    assign len_sat  = (32'(i_list_length) > LIST_DEPTH) ? LW'(LIST_DEPTH)
                                                         : LW'(i_list_length);

    assign load.exc = in_xfer && field_ok && (i_req_type == wtps_pkg::REQ_EXC_ENTRY);
    assign load.inc = in_xfer && field_ok && (i_req_type == wtps_pkg::REQ_INC_ENTRY);
    assign launch   = in_xfer && field_ok && (i_req_type == wtps_pkg::REQ_TOKEN);
    assign start_sum = in_xfer && (i_req_type == wtps_pkg::REQ_END);

    // ------------------------------------------------------------------
    // Cell chain. A token enters cell 0 straight from the input transfer
    // together with the current lengths of its field.
    // ------------------------------------------------------------------
    assign probe[0].valid   = launch;
    assign probe[0].ex_hit  = 1'b0;
    assign probe[0].inc_hit = 1'b0;
    assign c_field[0]       = fsel;
    assign c_token[0]       = i_token_id;
    assign c_inc[0]         = r_inc_len[fsel];
    assign c_exc[0]         = r_exc_len[fsel];
    assign c_rank[0]        = '0;

    for (genvar j = 0; j < LIST_DEPTH; j++) begin : g_cell
        wtps_cell #(
            .INDEX       (j),
            .FIELD_COUNT (FIELD_COUNT),
            .LIST_DEPTH  (LIST_DEPTH),
            .TOKEN_BITS  (TOKEN_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_load       (load),
            .i_load_slot  (i_slot),
            .i_load_field (fsel),
            .i_load_token (i_token_id),
            .i_probe      (probe[j]),
            .i_field      (c_field[j]),
            .i_token      (c_token[j]),
            .i_inc_len    (c_inc[j]),
            .i_exc_len    (c_exc[j]),
            .i_rank       (c_rank[j]),
            .o_probe      (probe[j+1]),
            .o_field      (c_field[j+1]),
            .o_token      (c_token[j+1]),
            .o_inc_len    (c_inc[j+1]),
            .o_exc_len    (c_exc[j+1]),
            .o_rank       (c_rank[j+1])
        );
    end

    assign scan_done  = probe[LIST_DEPTH].valid;
    assign last_field = c_field[LIST_DEPTH];

    // ------------------------------------------------------------------
    // Score unit: one field per cycle. The first excluded field stops the
    // sum; later fields are still visited but add nothing.
    // ------------------------------------------------------------------
    assign weight_sel = (32'(r_fidx) < wtps_pkg::WEIGHT_REGS)
                        ? r_weight[wtps_pkg::WREG_IDX_W'(r_fidx)] : '0;
    assign diff       = r_inc_len[r_fidx] - r_best[r_fidx];
    assign diff_s     = PROD_W'(diff);
    assign weight_s   = PROD_W'(weight_sel);
    assign prod       = diff_s * weight_s;
    assign take_term  = !r_stop && !r_seen[r_fidx] && r_apply
                        && (weight_sel != '0) && (r_best[r_fidx] < r_inc_len[r_fidx]);
    assign sum_last   = (r_fidx == FW'(FIELD_COUNT - 1));

    // Clamp to the signed score range.
    assign acc_sat = (r_acc > SAT_HI) ? SAT_HI :
                     (r_acc < SAT_LO) ? SAT_LO : r_acc;

    // The result register must be free or emptying to take the new result.
    assign emit_now = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (launch) begin
                    n_state = ST_SCAN;
                end else if (start_sum) begin
                    n_state = ST_SUM;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SUM: begin
                if (sum_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_now) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apply <= 1'b1;
            for (int k = 0; k < wtps_pkg::WEIGHT_REGS; k++) begin
                r_weight[k] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                wtps_pkg::CFG_APPLY: begin
                    r_apply <= i_cfg_data[0];
                end
                default: begin
                    if (i_cfg_index inside {[wtps_pkg::CFG_WEIGHT0 : wtps_pkg::CFG_WEIGHT_LAST]})
                    begin
                        r_weight[wtps_pkg::WREG_IDX_W'(i_cfg_index - wtps_pkg::CFG_WEIGHT0)]
                            <= i_cfg_data;
                    end
                end
            endcase
        end
    end

    // List lengths.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < FIELD_COUNT; f++) begin
                r_inc_len[f] <= '0;
                r_exc_len[f] <= '0;
            end
        end else if (in_xfer && field_ok) begin
            if (i_req_type == wtps_pkg::REQ_INC_LEN) begin
                r_inc_len[fsel] <= len_sat;
            end
            if (i_req_type == wtps_pkg::REQ_EXC_LEN) begin
                r_exc_len[fsel] <= len_sat;
            end
        end
    end

    // Candidate state: fold in a finished probe, clear after the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || emit_now) begin
            for (int f = 0; f < FIELD_COUNT; f++) begin
                r_best[f] <= LW'(LIST_DEPTH);
                r_seen[f] <= 1'b0;
            end
        end else if (scan_done) begin
            if (probe[LIST_DEPTH].ex_hit) begin
                r_seen[last_field] <= 1'b1;
            end
            if (probe[LIST_DEPTH].inc_hit && (c_rank[LIST_DEPTH] < r_best[last_field])) begin
                r_best[last_field] <= c_rank[LIST_DEPTH];
            end
        end
    end

    // Accumulator walk.
    always_ff @(posedge i_clk) begin
        if (start_sum) begin
            r_fidx <= '0;
            r_acc  <= '0;
            r_stop <= 1'b0;
            r_code <= '0;
        end else if (r_state == ST_SUM) begin
            if (!sum_last) begin
                r_fidx <= r_fidx + FW'(1);
            end
            if (!r_stop && r_seen[r_fidx]) begin
                r_stop <= 1'b1;
                r_code <= wtps_pkg::CODE_BITS'(r_fidx) + wtps_pkg::CODE_BITS'(1);
            end
            if (take_term) begin
                r_acc <= r_acc + ACC_W'(prod);
            end
        end
    end

    // Result register: hold while stalled, advance on emit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_now) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_now) begin
            r_score        <= wtps_pkg::SCORE_BITS'(acc_sat);
            r_rejected     <= r_stop;
            r_reject_cause <= r_code;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_score        = r_score;
    assign o_rejected     = r_rejected;
    assign o_reject_cause = r_reject_cause;

endmodule

`default_nettype wire

FILE: design/wtps_cell.sv
// One list position of the scorer chain: holds the include and exclude entry
// of that position for every field and checks a passing token against them.
// Depends on wtps_pkg.
`default_nettype none

module wtps_cell #(
    parameter int INDEX       = 0,
    parameter int FIELD_COUNT = 6,
    parameter int LIST_DEPTH  = 16,
    parameter int TOKEN_BITS  = 12,
    localparam int FW = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1,
    localparam int LW = $clog2(LIST_DEPTH + 1)
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wtps_pkg::t_load                     i_load,
    input  wire  [wtps_pkg::SLOT_BITS-1:0]      i_load_slot,
    input  wire  [FW-1:0]                       i_load_field,
    input  wire  [TOKEN_BITS-1:0]               i_load_token,
    input  wtps_pkg::t_probe                    i_probe,
    input  wire  [FW-1:0]                       i_field,
    input  wire  [TOKEN_BITS-1:0]               i_token,
    input  wire  [LW-1:0]                       i_inc_len,
    input  wire  [LW-1:0]                       i_exc_len,
    input  wire  [LW-1:0]                       i_rank,
    output wtps_pkg::t_probe                    o_probe,
    output logic [FW-1:0]                       o_field,
    output logic [TOKEN_BITS-1:0]               o_token,
    output logic [LW-1:0]                       o_inc_len,
    output logic [LW-1:0]                       o_exc_len,
    output logic [LW-1:0]                       o_rank
);

    logic [TOKEN_BITS-1:0] r_inc [FIELD_COUNT];
    logic [TOKEN_BITS-1:0] r_exc [FIELD_COUNT];

    wtps_pkg::t_probe r_probe;
    logic [FW-1:0]         r_field;
    logic [TOKEN_BITS-1:0] r_token;
    logic [LW-1:0]         r_inc_len;
    logic [LW-1:0]         r_exc_len;
    logic [LW-1:0]         r_rank;

    logic             slot_match;
    logic             ex_hit;
    logic             inc_hit;
    wtps_pkg::t_probe n_probe;

    assign slot_match = (32'(i_load_slot) == INDEX);

    // Only the first include match along the chain counts.
    assign ex_hit  = (LW'(INDEX) < i_exc_len) && (r_exc[i_field] == i_token);
    assign inc_hit = !i_probe.inc_hit && (LW'(INDEX) < i_inc_len)
                     && (r_inc[i_field] == i_token);

    always_comb begin
        n_probe.valid   = i_probe.valid;
        n_probe.ex_hit  = i_probe.ex_hit | ex_hit;
        n_probe.inc_hit = i_probe.inc_hit | inc_hit;
    end

    always_ff @(posedge i_clk) begin
        if (i_load.exc && slot_match) begin
            r_exc[i_load_field] <= i_load_token;
        end
        if (i_load.inc && slot_match) begin
            r_inc[i_load_field] <= i_load_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_field   <= i_field;
        r_token   <= i_token;
        r_inc_len <= i_inc_len;
        r_exc_len <= i_exc_len;
        r_rank    <= inc_hit ? LW'(INDEX) : i_rank;
    end

    assign o_probe   = r_probe;
    assign o_field   = r_field;
    assign o_token   = r_token;
    assign o_inc_len = r_inc_len;
    assign o_exc_len = r_exc_len;
    assign o_rank    = r_rank;

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for weighted_token_profile_scorer_core: drives item,
// result and register channels and scores each candidate with a model kept here.
// Depends on wtps_pkg and the scorer RTL only.
module tb;

    localparam int NUM_FIELDS  = 6;
    localparam int LIST_LEN    = 16;
    localparam int TOK_W       = 12;
    localparam int SETTLE_CYC  = 40;     // covers a token walk or a full end pass
    localparam int HOLD_CYC    = 400;    // one long result hold-off
    localparam int HOLD_AFTER  = 30;     // results checked before the hold-off starts
    localparam int IDLE_LIMIT  = 3000;   // cycles with no transfer on any channel
    localparam int PHASE_ITEMS = 170;

    // Request codes the block ignores.
    localparam logic [wtps_pkg::REQ_BITS-1:0]  REQ_SPARE_A = 3'd6;
    localparam logic [wtps_pkg::REQ_BITS-1:0]  REQ_SPARE_B = 3'd7;
    localparam logic [wtps_pkg::CODE_BITS-1:0] CODE_NONE   = 3'd0;

    typedef struct packed {
        logic [wtps_pkg::REQ_BITS-1:0]    req;
        logic [wtps_pkg::FSEL_BITS-1:0]   fsel;
        logic [wtps_pkg::SLOT_BITS-1:0]   slot;
        logic [TOK_W-1:0]                 tok;
        logic [wtps_pkg::LEN_IN_BITS-1:0] len;
    } t_req_item;

    typedef struct packed {
        logic signed [wtps_pkg::SCORE_BITS-1:0] score;
        logic                                   rejected;
        logic [wtps_pkg::CODE_BITS-1:0]         code;
    } t_verdict;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic drv_valid = 1'b0;
    t_req_item drv_item = '0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [wtps_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [wtps_pkg::WEIGHT_BITS-1:0] cfg_data = '0;

    logic in_stall;
    logic out_valid;
    logic signed [wtps_pkg::SCORE_BITS-1:0] out_score;
    logic out_rejected;
    logic [wtps_pkg::CODE_BITS-1:0] out_cause;
    logic cfg_ready;

    weighted_token_profile_scorer_core u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (drv_valid),
        .o_in_stall     (in_stall),
        .i_req_type     (drv_item.req),
        .i_field_sel    (drv_item.fsel),
        .i_slot         (drv_item.slot),
        .i_token_id     (drv_item.tok),
        .i_list_length  (drv_item.len),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_score        (out_score),
        .o_rejected     (out_rejected),
        .o_reject_cause (out_cause),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Scoring model: lists, lengths, per-candidate marks and registers.
    logic [TOK_W-1:0] inc_list [NUM_FIELDS][LIST_LEN];
    logic [TOK_W-1:0] exc_list [NUM_FIELDS][LIST_LEN];
    int   inc_len [NUM_FIELDS];
    int   exc_len [NUM_FIELDS];
    int   cand_rank [NUM_FIELDS];
    logic cand_excluded [NUM_FIELDS];
    logic apply_w;
    int   weight [NUM_FIELDS];
    t_verdict pending_verdicts [$];

    // Stimulus planner's view of the lists, used to aim tokens at real entries
    // and to fill every slot below a length before that length is set.
    logic [TOK_W-1:0]    plan_inc [NUM_FIELDS][LIST_LEN];
    logic [TOK_W-1:0]    plan_exc [NUM_FIELDS][LIST_LEN];
    logic [LIST_LEN-1:0] plan_inc_wr [NUM_FIELDS];
    logic [LIST_LEN-1:0] plan_exc_wr [NUM_FIELDS];
    int plan_inc_len [NUM_FIELDS];
    int plan_exc_len [NUM_FIELDS];
    t_req_item item_backlog [$];
    int planned = 0;

    int items_taken = 0;
    int verdicts_checked = 0;
    int rejects_seen = 0;
    int reg_writes = 0;
    int errors = 0;
    logic item_took = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int pace_left = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    int idle_cycles = 0;

    function automatic void clear_state();
        int f;
        for (f = 0; f < NUM_FIELDS; f++) begin
            inc_len[f]       = 0;
            exc_len[f]       = 0;
            cand_rank[f]     = LIST_LEN;
            cand_excluded[f] = 1'b0;
            weight[f]        = 0;
            plan_inc_wr[f]   = '0;
            plan_exc_wr[f]   = '0;
            plan_inc_len[f]  = 0;
            plan_exc_len[f]  = 0;
        end
        apply_w = 1'b1;
    endfunction

    function automatic void set_register(input logic [wtps_pkg::CFG_INDEX_BITS-1:0] idx,
                                         input logic [wtps_pkg::WEIGHT_BITS-1:0] val);
        if (idx == wtps_pkg::CFG_APPLY)
            apply_w = val[0];
        else if (idx >= wtps_pkg::CFG_WEIGHT0 && idx <= wtps_pkg::CFG_WEIGHT_LAST)
            weight[int'(idx - wtps_pkg::CFG_WEIGHT0)] = int'($signed(val));
    endfunction

    // Advance the model by one accepted item; an end item queues its verdict.
    function automatic void fold_item(input t_req_item it);
        int f, n, j, sum;
        logic found, stop;
        t_verdict v;
        f = int'(it.fsel);
        n = (it.len > LIST_LEN) ? LIST_LEN : int'(it.len);
        if (it.req == wtps_pkg::REQ_END) begin
            sum = 0;
            stop = 1'b0;
            v.rejected = 1'b0;
            v.code = CODE_NONE;
            // Stop scoring at the lowest field that saw an excluded token.
            for (j = 0; j < NUM_FIELDS; j++) begin
                if (!stop && cand_excluded[j]) begin
                    stop = 1'b1;
                    v.rejected = 1'b1;
                    v.code = j[wtps_pkg::CODE_BITS-1:0] + 3'd1;
                end else if (!stop && apply_w && weight[j] != 0 &&
                             cand_rank[j] < inc_len[j]) begin
                    sum += (inc_len[j] - cand_rank[j]) * weight[j];
                end
            end
            if (sum > wtps_pkg::SCORE_MAX)
                sum = wtps_pkg::SCORE_MAX;
            if (sum < wtps_pkg::SCORE_MIN)
                sum = wtps_pkg::SCORE_MIN;
            v.score = sum[wtps_pkg::SCORE_BITS-1:0];
            pending_verdicts.push_back(v);
            for (j = 0; j < NUM_FIELDS; j++) begin
                cand_rank[j] = LIST_LEN;
                cand_excluded[j] = 1'b0;
            end
        end else if (it.req <= wtps_pkg::REQ_TOKEN && f < NUM_FIELDS) begin
            case (it.req)
                wtps_pkg::REQ_EXC_ENTRY: exc_list[f][it.slot] = it.tok;
                wtps_pkg::REQ_INC_ENTRY: inc_list[f][it.slot] = it.tok;
                wtps_pkg::REQ_INC_LEN:   inc_len[f] = n;
                wtps_pkg::REQ_EXC_LEN:   exc_len[f] = n;
                default: begin
                    for (j = 0; j < exc_len[f]; j++)
                        if (exc_list[f][j] == it.tok)
                            cand_excluded[f] = 1'b1;
                    found = 1'b0;
                    for (j = 0; j < inc_len[f]; j++) begin
                        if (!found && inc_list[f][j] == it.tok) begin
                            found = 1'b1;
                            if (j < cand_rank[f])
                                cand_rank[f] = j;
                        end
                    end
                end
            endcase
        end
    endfunction

    // Mostly random ids, with a small pool so that lists hold duplicates.
    function automatic int rand_tok();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4095);
    endfunction

    function automatic void plan_item(input logic [wtps_pkg::REQ_BITS-1:0] req, input int f,
                                      input int slot, input int tok, input int len);
        t_req_item it;
        it.req  = req;
        it.fsel = f[wtps_pkg::FSEL_BITS-1:0];
        it.slot = slot[wtps_pkg::SLOT_BITS-1:0];
        it.tok  = tok[TOK_W-1:0];
        it.len  = len[wtps_pkg::LEN_IN_BITS-1:0];
        item_backlog.push_back(it);
        if (req == wtps_pkg::REQ_END) begin
            planned++;
        end else if (req <= wtps_pkg::REQ_TOKEN && f < NUM_FIELDS) begin
            planned++;
            case (req)
                wtps_pkg::REQ_EXC_ENTRY: begin
                    plan_exc[f][it.slot] = it.tok;
                    plan_exc_wr[f][it.slot] = 1'b1;
                end
                wtps_pkg::REQ_INC_ENTRY: begin
                    plan_inc[f][it.slot] = it.tok;
                    plan_inc_wr[f][it.slot] = 1'b1;
                end
                wtps_pkg::REQ_INC_LEN: plan_inc_len[f] = (len > LIST_LEN) ? LIST_LEN : len;
                wtps_pkg::REQ_EXC_LEN: plan_exc_len[f] = (len > LIST_LEN) ? LIST_LEN : len;
                default: ;
            endcase
        end
    endfunction

    // Set a list length, first writing any slot below it that was never written.
    function automatic void plan_length(input logic [wtps_pkg::REQ_BITS-1:0] req,
                                        input int f, input int len);
        int eff, s;
        if (f < NUM_FIELDS) begin
            eff = (len > LIST_LEN) ? LIST_LEN : len;
            for (s = 0; s < eff; s++) begin
                if (req == wtps_pkg::REQ_INC_LEN && !plan_inc_wr[f][s])
                    plan_item(wtps_pkg::REQ_INC_ENTRY, f, s, rand_tok(),
                              $urandom_range(0, 31));
                else if (req == wtps_pkg::REQ_EXC_LEN && !plan_exc_wr[f][s])
                    plan_item(wtps_pkg::REQ_EXC_ENTRY, f, s, rand_tok(),
                              $urandom_range(0, 31));
            end
        end
        plan_item(req, f, $urandom_range(0, 15), rand_tok(), len);
    endfunction

    // Aim at exclude entries now and then, at include entries most of the time.
    function automatic int pick_token(input int f);
        int r;
        r = $urandom_range(0, 99);
        if (f >= NUM_FIELDS)
            return rand_tok();
        if (r < 12 && plan_exc_len[f] > 0)
            return int'(plan_exc[f][$urandom_range(0, plan_exc_len[f] - 1)]);
        if (r < 65 && plan_inc_len[f] > 0)
            return int'(plan_inc[f][$urandom_range(0, plan_inc_len[f] - 1)]);
        return rand_tok();
    endfunction

    function automatic void plan_reload();
        int f;
        f = $urandom_range(0, NUM_FIELDS - 1);
        case ($urandom_range(0, 3))
            0: plan_item(wtps_pkg::REQ_EXC_ENTRY, f, $urandom_range(0, 15), rand_tok(), 0);
            1: plan_item(wtps_pkg::REQ_INC_ENTRY, f, $urandom_range(0, 15), rand_tok(), 0);
            2: plan_length(wtps_pkg::REQ_INC_LEN, f, ($urandom_range(0, 3) == 0) ?
                           $urandom_range(0, 31) : $urandom_range(1, LIST_LEN));
            default: plan_length(wtps_pkg::REQ_EXC_LEN, f, ($urandom_range(0, 4) == 0) ?
                                 $urandom_range(0, 31) : $urandom_range(0, 3));
        endcase
    endfunction

    function automatic void plan_noise();
        logic [wtps_pkg::REQ_BITS-1:0] req;
        req = wtps_pkg::REQ_BITS'($urandom_range(0, 7));
        if (req == wtps_pkg::REQ_INC_LEN || req == wtps_pkg::REQ_EXC_LEN)
            plan_length(req, $urandom_range(0, 7), $urandom_range(0, 31));
        else
            plan_item(req, $urandom_range(0, 7), $urandom_range(0, 15),
                      $urandom_range(0, 4095), $urandom_range(0, 31));
    endfunction

    // One candidate: a few tokens, an occasional list load in between, then
    // the end item; a few candidates are left open to run into the next one.
    function automatic void plan_candidate();
        int ntok, k, f;
        ntok = $urandom_range(0, 6);
        for (k = 0; k < ntok; k++) begin
            if ($urandom_range(0, 9) == 0)
                plan_reload();
            f = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_FIELDS, 7)
                                            : $urandom_range(0, NUM_FIELDS - 1);
            plan_item(wtps_pkg::REQ_TOKEN, f, $urandom_range(0, 15), pick_token(f),
                      $urandom_range(0, 31));
        end
        if ($urandom_range(0, 19) != 0)
            plan_item(wtps_pkg::REQ_END, $urandom_range(0, 7), $urandom_range(0, 15),
                      $urandom_range(0, 4095), $urandom_range(0, 31));
    endfunction

    function automatic void plan_random(input int count);
        int goal, r, n, k;
        goal = planned + count;
        while (planned < goal) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                plan_noise();
            end else if (r < 30) begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    plan_reload();
            end else begin
                plan_candidate();
            end
        end
    endfunction

    function automatic void plan_directed();
        // Short include list on field 0, full list on field 5 via a length that saturates.
        plan_item(wtps_pkg::REQ_INC_ENTRY, 0, 0, 0, 0);
        plan_item(wtps_pkg::REQ_INC_ENTRY, 0, 1, 4095, 0);
        plan_length(wtps_pkg::REQ_INC_LEN, 0, 2);
        plan_item(wtps_pkg::REQ_INC_ENTRY, 5, 15, 12'hABC, 0);
        plan_length(wtps_pkg::REQ_INC_LEN, 5, 31);
        plan_item(wtps_pkg::REQ_EXC_ENTRY, 3, 0, 100, 0);
        plan_length(wtps_pkg::REQ_EXC_LEN, 3, 1);
        // Best rank improves; absent fields and spare codes fall through.
        plan_item(wtps_pkg::REQ_TOKEN, 0, 0, 4095, 0);
        plan_item(wtps_pkg::REQ_TOKEN, 5, 0, 12'hABC, 0);
        plan_item(wtps_pkg::REQ_TOKEN, 0, 0, 0, 0);
        plan_item(wtps_pkg::REQ_TOKEN, 6, 0, 4095, 0);
        plan_item(wtps_pkg::REQ_TOKEN, 7, 15, 0, 31);
        plan_item(REQ_SPARE_A, 0, 0, 0, 0);
        plan_item(REQ_SPARE_B, 7, 15, 4095, 31);
        plan_item(wtps_pkg::REQ_END, 0, 0, 0, 0);
        // Exclusion on field 3 cuts off fields 3 and above.
        plan_item(wtps_pkg::REQ_TOKEN, 0, 0, 0, 0);
        plan_item(wtps_pkg::REQ_TOKEN, 3, 0, 100, 0);
        plan_item(wtps_pkg::REQ_TOKEN, 5, 0, int'(plan_inc[5][0]), 0);
        plan_item(wtps_pkg::REQ_END, 7, 15, 4095, 31);
        // Empty candidate.
        plan_item(wtps_pkg::REQ_END, 0, 0, 0, 0);
        // Include list shrinks below a rank already recorded.
        plan_item(wtps_pkg::REQ_TOKEN, 0, 0, 4095, 0);
        plan_length(wtps_pkg::REQ_INC_LEN, 0, 1);
        plan_item(wtps_pkg::REQ_END, 0, 0, 0, 0);
        plan_length(wtps_pkg::REQ_INC_LEN, 0, 2);
        // Emptied exclude list no longer rejects.
        plan_length(wtps_pkg::REQ_EXC_LEN, 3, 0);
        plan_item(wtps_pkg::REQ_TOKEN, 3, 0, 100, 0);
        plan_item(wtps_pkg::REQ_END, 0, 0, 0, 0);
        // Loads aimed at absent fields.
        plan_item(wtps_pkg::REQ_EXC_ENTRY, 7, 0, 4095, 0);
        plan_length(wtps_pkg::REQ_INC_LEN, 6, 16);
    endfunction

    task automatic write_register(input logic [wtps_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [wtps_pkg::WEIGHT_BITS-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_profile(input logic apply,
                                   input logic [NUM_FIELDS*wtps_pkg::WEIGHT_BITS-1:0] wts);
        int k;
        write_register(wtps_pkg::CFG_APPLY, {{(wtps_pkg::WEIGHT_BITS-1){1'b0}}, apply});
        for (k = 0; k < NUM_FIELDS; k++)
            write_register(wtps_pkg::CFG_WEIGHT0 + wtps_pkg::CFG_INDEX_BITS'(k),
                           wts[k*wtps_pkg::WEIGHT_BITS +: wtps_pkg::WEIGHT_BITS]);
    endtask

    // Drain the backlog and all verdicts, then let a token walk finish.
    task automatic settle();
        while (item_backlog.size() != 0 || drv_valid)
            @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Item sender: bursts of random length separated by random gaps.
    always @(negedge clk) begin : drive_items
        logic nv;
        nv = drv_valid;
        if (rst_n && !(drv_valid && !item_took)) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (item_backlog.size() != 0) begin
                drv_item <= item_backlog.pop_front();
                nv = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(1, 12);
                    gap_left = $urandom_range(1, 10);
                end
            end
        end
        drv_valid <= nv;
    end

    // Result receiver: its own stall pattern, plus one long hold-off that
    // backs the block up into its item input.
    always @(negedge clk) begin : pace_results
        logic ns;
        ns = out_stall;
        if (rst_n) begin
            if (hold_left > 0) begin
                ns = 1'b1;
                hold_left--;
            end else if (!hold_done && verdicts_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYC - 1;
                ns = 1'b1;
            end else begin
                if (pace_left == 0) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: begin ns = 1'b0; pace_left = $urandom_range(20, 80); end
                        3, 4, 5, 6: begin ns = 1'b0; pace_left = $urandom_range(1, 6); end
                        default: begin ns = 1'b1; pace_left = $urandom_range(1, 8); end
                    endcase
                end
                pace_left--;
            end
        end
        out_stall <= ns;
    end

    // Sample every channel at the rising edge; check results before folding
    // in this edge's item so a stray result never meets a fresh verdict.
    always @(posedge clk) begin : watch_ports
        t_verdict want;
        item_took <= drv_valid && !in_stall;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (pending_verdicts.size() == 0) begin
                    $error("result with no verdict pending: score %0d", out_score);
                    errors++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (out_score !== want.score) begin
                        $error("score: expected %0d, got %0d", want.score, out_score);
                        errors++;
                    end
                    if (out_rejected !== want.rejected) begin
                        $error("rejected: expected %0d, got %0d", want.rejected, out_rejected);
                        errors++;
                    end
                    if (out_cause !== want.code) begin
                        $error("reject_cause: expected %0d, got %0d", want.code, out_cause);
                        errors++;
                    end
                    verdicts_checked++;
                    if (want.rejected)
                        rejects_seen++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                set_register(cfg_index, cfg_data);
                reg_writes++;
            end
            if (drv_valid && !in_stall) begin
                fold_item(drv_item);
                items_taken++;
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if ((drv_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : run
        logic [NUM_FIELDS*wtps_pkg::WEIGHT_BITS-1:0] wts;
        int p, k;
        clear_state();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pass under mixed extreme weights, field 4 unweighted.
        program_profile(1'b1, {8'h80, 8'h00, 8'hFF, 8'h05, 8'h80, 8'h7F});
        plan_directed();
        settle();

        // Random passes: reset weights, all max, all min, weighting off,
        // sparse random and full random weights.
        for (p = 1; p <= 6; p++) begin
            for (k = 0; k < NUM_FIELDS; k++)
                wts[k*wtps_pkg::WEIGHT_BITS +: wtps_pkg::WEIGHT_BITS] =
                    (p == 5 && $urandom_range(0, 3) == 0)
                    ? 8'h00 : wtps_pkg::WEIGHT_BITS'($urandom_range(0, 255));
            case (p)
                1: wts = '0;
                2: wts = {NUM_FIELDS{8'h7F}};
                3: wts = {NUM_FIELDS{8'h80}};
                default: ;
            endcase
            program_profile(p != 4, wts);
            plan_random(PHASE_ITEMS);
            settle();
        end

        if (pending_verdicts.size() != 0) begin
            $error("%0d verdicts never arrived", pending_verdicts.size());
            errors++;
        end
        $display("Run covered %0d items, %0d results (%0d rejected), %0d register writes",
                 items_taken, verdicts_checked, rejects_seen, reg_writes);
        $display("over seven weight profiles with one %0d-cycle result hold-off.", HOLD_CYC);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
design/wtps_pkg.sv
design/wtps_cell.sv
design/weighted_token_profile_scorer_core.sv
verif/tb.sv
